// ===== src/flvt_pkg.sv =====
// Shared types and constants for the AVC-to-FLV video tag packetizer.
package flvt_pkg;

	localparam int SPS_MAX_DEF     = 40;
	localparam int LENGTH_BITS_DEF = 24;

	localparam int SPS_LEN_W  = 6;   // holds the largest SPS_MAX
	localparam int SPS_ADDR_W = 6;
	localparam int PLEN_W     = 32;  // payload length field of a tag
	localparam int SIZE_W     = 25;
	localparam int Q_DEPTH    = 4;

	// command codes passed from front to back
	localparam logic [2:0] CMD_REC_HDR = 3'd0;  // 13 fixed bytes of the config record
	localparam logic [2:0] CMD_REC_SPS = 3'd1;  // stored SPS bytes
	localparam logic [2:0] CMD_REC_LEN = 3'd2;  // PPS count and PPS length
	localparam logic [2:0] CMD_FRM_HDR = 3'd3;  // 9-byte coded frame header
	localparam logic [2:0] CMD_BYTE    = 3'd4;  // one pass-through byte

	localparam logic [4:0] NAL_IDR = 5'd5;
	localparam logic [4:0] NAL_SPS = 5'd7;
	localparam logic [4:0] NAL_PPS = 5'd8;

	localparam logic [7:0] TAG_KEY_AVC    = 8'h17;
	localparam logic [7:0] TAG_INTER_AVC  = 8'h27;
	localparam logic [7:0] AVC_ONE        = 8'h01;
	localparam logic [7:0] AVC_LEN_SIZE   = 8'hFF;
	localparam logic [7:0] AVC_NUM_SPS    = 8'hE1;
	localparam logic [7:0] BYTE_ZERO      = 8'h00;

	localparam int REC_FIXED_BYTES = 16;
	localparam int FRM_HDR_BYTES   = 9;

	localparam logic       REC_KIND_CFG   = 1'b0;
	localparam logic       REC_KIND_FRAME = 1'b1;

	typedef struct packed {
		logic [2:0]            code;
		logic [7:0]            data;
		logic                  kind;
		logic                  last;
		logic                  idr;
		logic [SPS_LEN_W-1:0]  spsl;
		logic [PLEN_W-1:0]     plen;
	} cmd_t;

	typedef struct packed {
		logic                  en;
		logic [SPS_ADDR_W-1:0] addr;
		logic [7:0]            data;
	} store_wr_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== src/h264_nal_to_flv_video_tag_core.sv =====
// Top level: H.264 NAL byte stream in, FLV AVC video tag bodies out.
//
// channel  dir  tdata                                  tuser                      tlast
// s_axis   in   [7:0] nal_byte, [31:8] nal_length      [4:0] nal_type, [5] first  last_byte
// m_axis   out  [7:0] body_byte, [32:8] body_size      [0] record_kind, [1] start tag_end
//
// One input byte per cycle while s_axis_tready is high; the back end sends one body byte
// per cycle while m_axis_tready is high. Header bursts (13 or 9 bytes) and the SPS copy
// (up to SPS_MAX bytes) fill the 4-entry command queue and hold s_axis_tready low.
// A byte that writes the SPS store waits until the command queue is empty.
// arst_n clears all control state; the SPS store itself is not cleared.
module h264_nal_to_flv_video_tag_core
	import flvt_pkg::*;
#(
	parameter int SPS_MAX     = SPS_MAX_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // nal_byte, nal_length
	input  logic [5:0]  s_axis_tuser,   // nal_type, first_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // body_byte, body_size, zero fill
	output logic [1:0]  m_axis_tuser,   // record_kind, tag_start
	output logic        m_axis_tlast
);

	q_stat_t           q_stat;
	store_wr_t         store_wr;
	cmd_t              push_cmd, head;
	logic              push, pop;
	logic [7:0]        body_byte;
	logic              record_kind, tag_start, tag_end;
	logic [SIZE_W-1:0] body_size;

	flvt_front #(
		.SPS_MAX     (SPS_MAX),
		.LENGTH_BITS (LENGTH_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.nal_byte   (s_axis_tdata[7:0]),
		.nal_type   (s_axis_tuser[4:0]),
		.nal_length (s_axis_tdata[31:8]),
		.first_byte (s_axis_tuser[5]),
		.last_byte  (s_axis_tlast),
		.q_stat     (q_stat),
		.push       (push),
		.cmd        (push_cmd),
		.store_wr   (store_wr)
	);

	flvt_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	flvt_back #(
		.SPS_MAX (SPS_MAX)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.store_wr    (store_wr),
		.head        (head),
		.q_empty     (q_stat.empty),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.body_byte   (body_byte),
		.record_kind (record_kind),
		.tag_start   (tag_start),
		.tag_end     (tag_end),
		.body_size   (body_size)
	);

	assign m_axis_tdata = {7'd0, body_size, body_byte};
	assign m_axis_tuser = {tag_start, record_kind};
	assign m_axis_tlast = tag_end;

	// store must not change under a pending record
	a_store_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		store_wr.en |-> q_stat.empty)
		else $error("SPS store written while commands pending");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("command queue underflow");

	a_size_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !tag_start |-> body_size == '0)
		else $error("body size outside tag start");

endmodule

// ===== src/flvt_front.sv =====
// Front end: tracks NAL position, classifies bytes and issues tag commands.
module flvt_front
	import flvt_pkg::*;
#(
	parameter int SPS_MAX     = SPS_MAX_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] nal_byte,
	input  logic [4:0] nal_type,
	input  logic [23:0] nal_length,
	input  logic       first_byte,
	input  logic       last_byte,
	input  q_stat_t    q_stat,
	output logic       push,
	output cmd_t       cmd,
	output store_wr_t  store_wr
);

	localparam logic [LENGTH_BITS-1:0] L0 = '0;

	logic [LENGTH_BITS-1:0] pos_q, len_q;
	logic [4:0]             type_q;
	logic [2:0]             strip_q;
	logic [SPS_LEN_W-1:0]   spsl_q;
	logic                   spsv_q, drop_q;

	logic [LENGTH_BITS-1:0] len_in, e_len, e_pos, p_rec, p_frm;
	logic [4:0]             e_type;
	logic [2:0]             e_strip, new_strip;
	logic [SPS_LEN_W-1:0]   e_spsl;
	logic                   e_spsv, e_drop, sps_fits;
	logic                   active, acc, wr_cond, push_cond, drop_set, spsv_clr, strip_set;
	logic                   at_end;

	assign len_in   = LENGTH_BITS'(nal_length);
	assign sps_fits = (len_in > (L0 + 4)) && (len_in <= (L0 + LENGTH_BITS'(SPS_MAX + 4)));

	// values as seen after a first_byte has loaded the new NAL
	always_comb begin
		e_len   = first_byte ? len_in : len_q;
		e_type  = first_byte ? nal_type : type_q;
		e_pos   = first_byte ? L0 : pos_q;
		e_strip = first_byte ? 3'd4 : strip_q;
		e_spsl  = spsl_q;
		e_spsv  = spsv_q;
		e_drop  = first_byte ? 1'b0 : drop_q;
		if (first_byte && nal_type == NAL_SPS) begin
			e_spsl = sps_fits ? SPS_LEN_W'(len_in - 4) : '0;
			e_spsv = sps_fits;
		end
		if (first_byte && nal_type == NAL_PPS)
			e_drop = !(spsv_q && len_in > (L0 + 4));
	end

	assign active    = e_pos < e_len;
	assign at_end    = e_pos == e_len - 1;
	assign p_rec     = e_len - LENGTH_BITS'(4);
	assign new_strip = (nal_byte == BYTE_ZERO) ? 3'd4 : 3'd3;
	assign p_frm     = e_len - LENGTH_BITS'(new_strip);

	always_comb begin
		wr_cond   = 1'b0;
		push_cond = 1'b0;
		drop_set  = 1'b0;
		spsv_clr  = 1'b0;
		strip_set = 1'b0;
		cmd       = '0;
		cmd.spsl  = e_spsl;
		if (active && !e_drop) begin
			if (e_type == NAL_SPS) begin
				wr_cond = (e_pos >= L0 + 4) && ((e_pos - 4) < LENGTH_BITS'(e_spsl));
			end else if (e_type == NAL_PPS) begin
				cmd.plen = PLEN_W'(p_rec);
				cmd.kind = REC_KIND_CFG;
				if (e_pos == L0) begin
					cmd.code  = CMD_REC_HDR;
					push_cond = 1'b1;
					spsv_clr  = 1'b1;
				end else if (e_pos == L0 + 1) begin
					cmd.code  = CMD_REC_SPS;
					push_cond = e_spsl != '0;
				end else if (e_pos == L0 + 2) begin
					cmd.code  = CMD_REC_LEN;
					push_cond = 1'b1;
				end else if (e_pos >= L0 + 4) begin
					cmd.code  = CMD_BYTE;
					cmd.data  = nal_byte;
					cmd.last  = at_end;
					push_cond = 1'b1;
				end
			end else begin
				cmd.kind = REC_KIND_FRAME;
				if (e_pos == L0 + 2) begin
					strip_set = 1'b1;
					if (e_len < LENGTH_BITS'(new_strip)) begin
						drop_set = 1'b1;
					end else begin
						cmd.code  = CMD_FRM_HDR;
						cmd.idr   = e_type == NAL_IDR;
						cmd.plen  = PLEN_W'(p_frm);
						push_cond = 1'b1;
					end
				end else if (e_pos > L0 + 2 && e_pos >= LENGTH_BITS'(e_strip)) begin
					cmd.code  = CMD_BYTE;
					cmd.data  = nal_byte;
					cmd.last  = at_end;
					push_cond = 1'b1;
				end
			end
		end
	end

	// SPS writes wait until the back end no longer reads the store
	assign in_ready = !q_stat.full && !(wr_cond && !q_stat.empty);
	assign acc      = in_valid && in_ready;
	assign push     = acc && push_cond;

	assign store_wr.en   = acc && wr_cond;
	assign store_wr.addr = SPS_ADDR_W'(e_pos - 4);
	assign store_wr.data = nal_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			len_q   <= '0;
			type_q  <= '0;
			strip_q <= 3'd4;
			spsl_q  <= '0;
			spsv_q  <= 1'b0;
			drop_q  <= 1'b0;
		end else if (acc) begin
			len_q   <= e_len;
			type_q  <= e_type;
			spsl_q  <= e_spsl;
			spsv_q  <= e_spsv && !spsv_clr;
			drop_q  <= e_drop || drop_set;
			strip_q <= strip_set ? new_strip : e_strip;
			if (active)
				pos_q <= last_byte ? e_len : e_pos + 1'b1;
			else
				pos_q <= e_pos;
		end
	end

endmodule

// ===== src/flvt_cmdq.sv =====
// Small command FIFO between the front and back ends.
module flvt_cmdq
	import flvt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	input  logic    pop,
	output cmd_t    head,
	output q_stat_t stat
);

	localparam int PW = $clog2(Q_DEPTH);
	localparam int CW = $clog2(Q_DEPTH + 1);

	cmd_t          slot_q [Q_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign head       = slot_q[rd_ptr_q];
	assign stat.full  = cnt_q == CW'(Q_DEPTH);
	assign stat.empty = cnt_q == '0;

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== src/flvt_back.sv =====
// Back end: SPS store and expansion of commands into tag body bytes.
module flvt_back
	import flvt_pkg::*;
#(
	parameter int SPS_MAX = SPS_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  store_wr_t         store_wr,
	input  cmd_t              head,
	input  logic              q_empty,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        body_byte,
	output logic              record_kind,
	output logic              tag_start,
	output logic              tag_end,
	output logic [SIZE_W-1:0] body_size
);

	localparam int AW    = $clog2(SPS_MAX);
	localparam int IDX_W = $clog2(SPS_MAX + 14);

	logic [7:0]        sps_mem [SPS_MAX];
	logic [IDX_W-1:0]  k_q;

	logic [7:0]        e_byte;
	logic              e_mem, e_start, e_end, e_last;
	logic [AW-1:0]     e_raddr;
	logic [SIZE_W-1:0] e_size;

	logic              valid_s1, mem_s1, kind_s1, start_s1, end_s1;
	logic [7:0]        byte_s1, rd_s1;
	logic [SIZE_W-1:0] size_s1;

	logic              out_valid_q, kind_q, start_q, end_q;
	logic [7:0]        byte_q;
	logic [SIZE_W-1:0] size_q;

	logic              move_out, load_s1;

	// element k of the command at the queue head
	always_comb begin
		e_byte  = BYTE_ZERO;
		e_mem   = 1'b0;
		e_raddr = '0;
		e_start = 1'b0;
		e_end   = 1'b0;
		e_last  = 1'b0;
		e_size  = '0;
		unique case (head.code)
			CMD_REC_HDR: begin
				e_last = k_q == IDX_W'(12);
				e_size = SIZE_W'(REC_FIXED_BYTES) + SIZE_W'(head.spsl) + SIZE_W'(head.plen);
				case (int'(k_q))
					0: begin
						e_byte  = TAG_KEY_AVC;
						e_start = 1'b1;
					end
					5:       e_byte = AVC_ONE;
					6, 7, 8: begin
						// profile, compatibility, level
						e_mem   = 1'b1;
						e_raddr = AW'(k_q - IDX_W'(5));
					end
					9:       e_byte = AVC_LEN_SIZE;
					10:      e_byte = AVC_NUM_SPS;
					12:      e_byte = 8'(head.spsl);
					default: e_byte = BYTE_ZERO;
				endcase
			end
			CMD_REC_SPS: begin
				e_last  = k_q == IDX_W'(head.spsl) - 1'b1;
				e_mem   = 1'b1;
				e_raddr = AW'(k_q);
			end
			CMD_REC_LEN: begin
				e_last = k_q == IDX_W'(2);
				case (int'(k_q))
					0:       e_byte = AVC_ONE;
					1:       e_byte = head.plen[15:8];
					default: e_byte = head.plen[7:0];
				endcase
			end
			CMD_FRM_HDR: begin
				e_last = k_q == IDX_W'(8);
				e_size = SIZE_W'(FRM_HDR_BYTES) + SIZE_W'(head.plen);
				case (int'(k_q))
					0: begin
						e_byte  = head.idr ? TAG_KEY_AVC : TAG_INTER_AVC;
						e_start = 1'b1;
					end
					1:       e_byte = AVC_ONE;
					5:       e_byte = head.plen[31:24];
					6:       e_byte = head.plen[23:16];
					7:       e_byte = head.plen[15:8];
					8: begin
						e_byte = head.plen[7:0];
						e_end  = head.plen == '0;
					end
					default: e_byte = BYTE_ZERO;
				endcase
			end
			CMD_BYTE: begin
				e_last = 1'b1;
				e_byte = head.data;
				e_end  = head.last;
			end
			default: e_last = 1'b1;
		endcase
		if (!e_start)
			e_size = '0;
	end

	assign move_out = valid_s1 && (!out_valid_q || out_ready);
	assign load_s1  = !q_empty && (!valid_s1 || move_out);
	assign pop      = load_s1 && e_last;

	always_ff @(posedge clk) begin
		if (store_wr.en)
			sps_mem[store_wr.addr[AW-1:0]] <= store_wr.data;
		if (load_s1)
			rd_s1 <= sps_mem[e_raddr];
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			byte_s1  <= e_byte;
			mem_s1   <= e_mem;
			kind_s1  <= head.kind;
			start_s1 <= e_start;
			end_s1   <= e_end;
			size_s1  <= e_size;
		end
		if (move_out) begin
			byte_q  <= mem_s1 ? rd_s1 : byte_s1;
			kind_q  <= kind_s1;
			start_q <= start_s1;
			end_q   <= end_s1;
			size_q  <= size_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1)
				k_q <= e_last ? '0 : k_q + 1'b1;
			if (load_s1)
				valid_s1 <= 1'b1;
			else if (move_out)
				valid_s1 <= 1'b0;
			if (move_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign body_byte   = byte_q;
	assign record_kind = kind_q;
	assign tag_start   = start_q;
	assign tag_end     = end_q;
	assign body_size   = size_q;

endmodule
